// ===== rtl/jppi_pkg.sv =====
// ============================================================================
// jppi_pkg
// Shared types and constants for the JSON pretty-print indenter.
// ============================================================================
`default_nettype none

package jppi_pkg;

    localparam int DEPTH_W         = 5;
    localparam int TAB_W           = DEPTH_W + 1;
    localparam int DEPTH_LIMIT_DEF = 31;

    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_COMMA  = 8'h2C;

    typedef logic [DEPTH_W-1:0] t_depth;
    typedef logic [TAB_W-1:0]   t_tabs;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PRE_LF,
        ST_PRE_TAB,
        ST_BYTE,
        ST_POST_LF,
        ST_POST_TAB
    } t_state;

    typedef enum logic [1:0] {
        EMIT_LF,
        EMIT_TAB,
        EMIT_BYTE
    } t_emit_sel;

    typedef struct packed {
        logic      load;
        logic      emit;
        t_emit_sel sel;
        logic      last;
    } t_cmd;

    typedef struct packed {
        logic in_pre;
        logic post;
        logic tabs_zero;
        logic tabs_one;
        logic slot_free;
    } t_sts;

endpackage

`default_nettype wire

// ===== rtl/jppi_if.sv =====
// ============================================================================
// jppi_if
// Valid/ready channels: input text words and output text words.
// ============================================================================
`default_nettype none

interface jppi_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       doc_start;

    modport source (output valid, output text_byte, output doc_start, input ready);
    modport sink   (input valid, input text_byte, input doc_start, output ready);
endinterface

interface jppi_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       run_last;

    modport source (output valid, output out_byte, output run_last, input ready);
    modport sink   (input valid, input out_byte, input run_last, output ready);
endinterface

`default_nettype wire

// ===== rtl/jppi_dp.sv =====
// ============================================================================
// jppi_dp
// Datapath: nesting depths, tab counter, held byte and output register.
// ============================================================================
`default_nettype none

module jppi_dp #(
    parameter int DEPTH_LIMIT = jppi_pkg::DEPTH_LIMIT_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic [7:0]    i_text_byte,
    input  wire logic          i_doc_start,
    input  wire logic          i_out_ready,
    input  wire jppi_pkg::t_cmd i_cmd,
    output jppi_pkg::t_sts     o_sts,
    output logic               o_out_valid,
    output logic [7:0]         o_out_byte,
    output logic               o_run_last
);

    localparam jppi_pkg::t_depth LIMIT = jppi_pkg::t_depth'(DEPTH_LIMIT);

    jppi_pkg::t_depth r_brace, n_brace;
    jppi_pkg::t_depth r_brack, n_brack;
    logic             r_past;
    logic             r_post;
    logic [7:0]       r_byte;
    jppi_pkg::t_tabs  r_tabs;
    logic             r_out_valid;
    logic [7:0]       r_out_byte;
    logic             r_out_last;

    jppi_pkg::t_depth base_brace, base_brack;
    logic             past_eff;
    logic             is_open, is_close;
    logic [7:0]       emit_byte;

    always_comb begin
        base_brace = i_doc_start ? '0 : r_brace;
        base_brack = i_doc_start ? '0 : r_brack;
        past_eff   = i_doc_start ? 1'b0 : r_past;
        is_open    = (i_text_byte == jppi_pkg::CH_LBRACE) || (i_text_byte == jppi_pkg::CH_LBRACK);
        is_close   = (i_text_byte == jppi_pkg::CH_RBRACE) || (i_text_byte == jppi_pkg::CH_RBRACK);
        n_brace    = base_brace;
        n_brack    = base_brack;
        case (i_text_byte)
            jppi_pkg::CH_LBRACE: n_brace = (base_brace >= LIMIT) ? LIMIT : base_brace + 1'b1;
            jppi_pkg::CH_RBRACE: n_brace = (base_brace == '0) ? '0 : base_brace - 1'b1;
            jppi_pkg::CH_LBRACK: n_brack = (base_brack >= LIMIT) ? LIMIT : base_brack + 1'b1;
            jppi_pkg::CH_RBRACK: n_brack = (base_brack == '0) ? '0 : base_brack - 1'b1;
            default: ;
        endcase
    end

    always_comb begin
        case (i_cmd.sel)
            jppi_pkg::EMIT_LF:  emit_byte = jppi_pkg::CH_LF;
            jppi_pkg::EMIT_TAB: emit_byte = jppi_pkg::CH_TAB;
            default:            emit_byte = r_byte;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_brace     <= '0;
            r_brack     <= '0;
            r_past      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_brace <= n_brace;
                r_brack <= n_brack;
                r_past  <= 1'b1;
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_byte <= i_text_byte;
            r_post <= is_open || (i_text_byte == jppi_pkg::CH_COMMA);
            r_tabs <= jppi_pkg::t_tabs'(n_brace) + jppi_pkg::t_tabs'(n_brack);
        end else if (i_cmd.emit && i_cmd.sel == jppi_pkg::EMIT_TAB) begin
            r_tabs <= r_tabs - 1'b1;
        end
        if (i_cmd.emit) begin
            r_out_byte <= emit_byte;
            r_out_last <= i_cmd.last;
        end
    end

    always_comb begin
        o_sts.in_pre    = is_close && past_eff;
        o_sts.post      = r_post;
        o_sts.tabs_zero = (r_tabs == '0);
        o_sts.tabs_one  = (r_tabs == jppi_pkg::t_tabs'(1));
        o_sts.slot_free = !r_out_valid || i_out_ready;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_byte  = r_out_byte;
    assign o_run_last  = r_out_last;

endmodule

`default_nettype wire

// ===== rtl/jppi_ctrl.sv =====
// ============================================================================
// jppi_ctrl
// Controller: sequences line feed, tabs and the byte for each input word.
// ============================================================================
`default_nettype none

module jppi_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    input  wire jppi_pkg::t_sts i_sts,
    output logic                o_in_ready,
    output jppi_pkg::t_cmd      o_cmd
);

    jppi_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= jppi_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            jppi_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = i_sts.in_pre ? jppi_pkg::ST_PRE_LF : jppi_pkg::ST_BYTE;
                end
            end
            jppi_pkg::ST_PRE_LF: begin
                if (i_sts.slot_free) begin
                    n_state = i_sts.tabs_zero ? jppi_pkg::ST_BYTE : jppi_pkg::ST_PRE_TAB;
                end
            end
            jppi_pkg::ST_PRE_TAB: begin
                if (i_sts.slot_free && i_sts.tabs_one) begin
                    n_state = jppi_pkg::ST_BYTE;
                end
            end
            jppi_pkg::ST_BYTE: begin
                if (i_sts.slot_free) begin
                    n_state = i_sts.post ? jppi_pkg::ST_POST_LF : jppi_pkg::ST_IDLE;
                end
            end
            jppi_pkg::ST_POST_LF: begin
                if (i_sts.slot_free) begin
                    n_state = i_sts.tabs_zero ? jppi_pkg::ST_IDLE : jppi_pkg::ST_POST_TAB;
                end
            end
            jppi_pkg::ST_POST_TAB: begin
                if (i_sts.slot_free && i_sts.tabs_one) begin
                    n_state = jppi_pkg::ST_IDLE;
                end
            end
            default: n_state = jppi_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        o_cmd.load = 1'b0;
        o_cmd.emit = 1'b0;
        o_cmd.sel  = jppi_pkg::EMIT_BYTE;
        o_cmd.last = 1'b0;
        case (r_state)
            jppi_pkg::ST_IDLE: begin
                o_in_ready = i_rst_n;
                o_cmd.load = i_in_valid && i_rst_n;
            end
            jppi_pkg::ST_PRE_LF: begin
                o_cmd.emit = i_sts.slot_free;
                o_cmd.sel  = jppi_pkg::EMIT_LF;
            end
            jppi_pkg::ST_PRE_TAB: begin
                o_cmd.emit = i_sts.slot_free;
                o_cmd.sel  = jppi_pkg::EMIT_TAB;
            end
            jppi_pkg::ST_BYTE: begin
                o_cmd.emit = i_sts.slot_free;
                o_cmd.sel  = jppi_pkg::EMIT_BYTE;
                o_cmd.last = !i_sts.post;
            end
            jppi_pkg::ST_POST_LF: begin
                o_cmd.emit = i_sts.slot_free;
                o_cmd.sel  = jppi_pkg::EMIT_LF;
                o_cmd.last = i_sts.tabs_zero;
            end
            jppi_pkg::ST_POST_TAB: begin
                o_cmd.emit = i_sts.slot_free;
                o_cmd.sel  = jppi_pkg::EMIT_TAB;
                o_cmd.last = i_sts.tabs_one;
            end
            default: ;
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/json_pretty_print_indenter_unit.sv =====
// ============================================================================
// json_pretty_print_indenter_unit
// Re-indents compact JSON text: line feed plus tabs around structural bytes.
// ============================================================================
//  Channel | Dir | Payload               | Handshake
//  i_in    | in  | text_byte, doc_start  | valid/ready
//  o_out   | out | out_byte, run_last    | valid/ready
//
//  One input word produces N output words (1 for plain bytes, up to 64), sent
//  through the output register at one word per cycle unless the output stalls.
//  Next word is accepted while the last output word still waits in the register.
//  Reset clears depths, first-byte flag, state and output valid.
//  Output stalls hold the sequencer; input is not taken until the sequence ends.
// ============================================================================
`default_nettype none

module json_pretty_print_indenter_unit #(
    parameter int DEPTH_LIMIT = jppi_pkg::DEPTH_LIMIT_DEF
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    jppi_in_if.sink     i_in,
    jppi_out_if.source  o_out
);

    jppi_pkg::t_cmd cmd;
    jppi_pkg::t_sts sts;
    logic           in_ready;
    logic           out_valid;
    logic [7:0]     out_byte;
    logic           run_last;

    jppi_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_sts      (sts),
        .o_in_ready (in_ready),
        .o_cmd      (cmd)
    );

    jppi_dp #(
        .DEPTH_LIMIT (DEPTH_LIMIT)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_text_byte (i_in.text_byte),
        .i_doc_start (i_in.doc_start),
        .i_out_ready (o_out.ready),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_valid (out_valid),
        .o_out_byte  (out_byte),
        .o_run_last  (run_last)
    );

    assign i_in.ready     = in_ready;
    assign o_out.valid    = out_valid;
    assign o_out.out_byte = out_byte;
    assign o_out.run_last = run_last;

endmodule

`default_nettype wire
